// ===== src/sorted_priority_queue_assert.svh =====
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted priority queue: same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted priority queue: next-cycle check failed");

`endif

// ===== src/spq_pkg.sv =====
// Package with the types, codes and sizes of the sorted priority queue.
package spq_pkg;

  localparam int SPQ_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int PRIO_W       = 16;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 3;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [VALUE_W-1:0]  value;
    logic [PRIO_W-1:0]   prio;
  } cell_cmd_t;

  typedef struct packed {
    logic                valid;
    logic [VALUE_W-1:0]  value;
    logic [PRIO_W-1:0]   prio;
  } cell_t;

endpackage

// ===== src/spq_cell.sv =====
// One cell of the sorted chain: holds a single entry and trades it with its neighbours.
module spq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::cell_t    prev_q,
  input  logic              prev_gt,
  input  spq_pkg::cell_t    next_q,
  input  spq_pkg::cell_t    head_q,
  output spq_pkg::cell_t    cell_q,
  output logic              gt
);
  import spq_pkg::*;

  logic   valid_r, valid_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [PRIO_W-1:0]  prio_r, prio_nxt;

  // The new entry goes in front of every stored entry with a strictly larger priority.
  assign gt = valid_r && ($signed(prio_r) > $signed(cmd.prio));

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    case (cmd.op)
      OP_INSERT: begin
        if (prev_gt) begin
          valid_nxt = prev_q.valid;
          value_nxt = prev_q.value;
          prio_nxt  = prev_q.prio;
        end else if (prev_q.valid && (gt || !valid_r)) begin
          valid_nxt = 1'b1;
          value_nxt = cmd.value;
          prio_nxt  = cmd.prio;
        end
      end
      OP_POP: begin
        valid_nxt = next_q.valid;
        value_nxt = next_q.value;
        prio_nxt  = next_q.prio;
      end
      OP_ROTATE: begin
        // The tail cell takes the head, so after one pass the order is restored.
        if (next_q.valid) begin
          value_nxt = next_q.value;
          prio_nxt  = next_q.prio;
        end else if (valid_r) begin
          value_nxt = head_q.value;
          prio_nxt  = head_q.prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign cell_q = '{valid: valid_r, value: value_r, prio: prio_r};

endmodule

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue: a row of cells kept in ascending priority order.
//
// Commands are given on start with in_func, in_item_value and in_priority_req;
// a transfer takes place at a rising edge where start is high and busy is low.
// Insert places the entry after every stored entry of equal or smaller
// priority; a full queue rejects it with status full. Pop returns the head
// entry, or status underflow when the queue is empty. List emits every entry
// from head to tail, one per cycle, with out_last on the tail entry; an empty
// queue gives a single result with status empty. Function code 3 is ignored.
// Each result is on the out_ ports for one cycle, marked by out_valid, and the
// receiver cannot hold it off.
// Insert and pop give their result in the cycle after the transfer and a new
// command may follow at once, one per cycle. A list of N entries keeps busy
// high while the chain rotates once; its results are registered after the
// state register has entered list, and appear one per cycle, N in all.
// Reset (rst_n low at a clock edge) empties the queue and cancels a list.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic        [spq_pkg::FUNC_W-1:0]   in_func,
  input  logic signed [spq_pkg::VALUE_W-1:0]  in_item_value,
  input  logic signed [spq_pkg::PRIO_W-1:0]   in_priority_req,
  output logic                                out_valid,
  output logic signed [spq_pkg::VALUE_W-1:0]  out_item_value_res,
  output logic signed [spq_pkg::PRIO_W-1:0]   out_priority_res,
  output logic        [spq_pkg::STATUS_W-1:0] out_status,
  output logic                                out_last
);
  import spq_pkg::*;
  `include "sorted_priority_queue_assert.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] entry_count_r, entry_count_nxt;
  logic [CNT_W-1:0] list_idx_r, list_idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [PRIO_W-1:0]   out_prio_r, out_prio_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  cell_cmd_t cmd;
  cell_t     cell_q [CAPACITY];
  logic      cell_gt [CAPACITY];

  logic accept, full, empty, list_end;

  assign busy     = (state_r == S_LIST);
  assign accept   = start && !busy;
  assign full     = cell_q[CAPACITY-1].valid;
  assign empty    = !cell_q[0].valid;
  assign list_end = (list_idx_r == entry_count_r - CNT_W'(1));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_t prev_q, next_q;
    logic  prev_gt;
    if (i == 0) begin : g_first
      assign prev_q  = '{valid: 1'b1, value: '0, prio: '0};
      assign prev_gt = 1'b0;
    end else begin : g_inner
      assign prev_q  = cell_q[i-1];
      assign prev_gt = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_q = '{valid: 1'b0, value: '0, prio: '0};
    end else begin : g_body
      assign next_q = cell_q[i+1];
    end
    spq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .prev_q  (prev_q),
      .prev_gt (prev_gt),
      .next_q  (next_q),
      .head_q  (cell_q[0]),
      .cell_q  (cell_q[i]),
      .gt      (cell_gt[i])
    );
  end

  always_comb begin
    cmd.op    = OP_HOLD;
    cmd.value = in_item_value;
    cmd.prio  = in_priority_req;

    state_nxt       = state_r;
    entry_count_nxt = entry_count_r;
    list_idx_nxt    = list_idx_r;

    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_prio_nxt   = '0;
    out_status_nxt = ST_INSERTED;
    out_last_nxt   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_INSERT: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.op          = OP_INSERT;
                entry_count_nxt = entry_count_r + CNT_W'(1);
                out_status_nxt  = ST_INSERTED;
              end
            end
            FUNC_POP: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                cmd.op          = OP_POP;
                entry_count_nxt = entry_count_r - CNT_W'(1);
                out_value_nxt   = cell_q[0].value;
                out_prio_nxt    = cell_q[0].prio;
                out_status_nxt  = ST_POPPED;
              end
            end
            FUNC_LIST: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                state_nxt    = S_LIST;
                list_idx_nxt = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        // The head is emitted and the chain rotates by one entry each cycle.
        cmd.op         = OP_ROTATE;
        out_valid_nxt  = 1'b1;
        out_value_nxt  = cell_q[0].value;
        out_prio_nxt   = cell_q[0].prio;
        out_status_nxt = ST_LISTED;
        out_last_nxt   = list_end;
        list_idx_nxt   = list_idx_r + CNT_W'(1);
        if (list_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_count_r <= '0;
      list_idx_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_count_r <= entry_count_nxt;
      list_idx_r    <= list_idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_prio_r   <= out_prio_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_item_value_res = out_value_r;
  assign out_priority_res   = out_prio_r;
  assign out_status         = out_status_r;
  assign out_last           = out_last_r;

  // Count and occupancy must agree; inserts report; lists end with busy low.
  `SPQ_ASSERT_NOW(a_count_empty, 1'b1, (entry_count_r == '0) == empty)
  `SPQ_ASSERT_NOW(a_count_full, 1'b1, (entry_count_r == CNT_W'(CAPACITY)) == full)
  `SPQ_ASSERT_NEXT(a_insert_done, accept && in_func == FUNC_INSERT && !full,
                   out_valid && out_status == ST_INSERTED && out_last)
  `SPQ_ASSERT_NOW(a_list_ends, out_valid && out_status == ST_LISTED && out_last, !busy)

endmodule

// ===== test/tb_top.sv =====
// Testbench for the sorted priority queue: directed and random commands against a queue model.
module tb_top;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [PRIO_W-1:0]   prio;
    logic [STATUS_W-1:0] status;
    logic                last;
  } queue_result_t;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic        [FUNC_W-1:0]    in_func;
  logic signed [VALUE_W-1:0]   in_item_value;
  logic signed [PRIO_W-1:0]    in_priority_req;
  logic                        out_valid;
  logic signed [VALUE_W-1:0]   out_item_value_res;
  logic signed [PRIO_W-1:0]    out_priority_res;
  logic        [STATUS_W-1:0]  out_status;
  logic                        out_last;

  // Model of the stored entries, head at index 0.
  logic signed [VALUE_W-1:0] model_values[$];
  logic signed [PRIO_W-1:0]  model_prios[$];
  queue_result_t             expected_results[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int idle_max       = 0;

  sorted_priority_queue #(
    .CAPACITY(SPQ_CAPACITY)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_item_value      (in_item_value),
    .in_priority_req    (in_priority_req),
    .out_valid          (out_valid),
    .out_item_value_res (out_item_value_res),
    .out_priority_res   (out_priority_res),
    .out_status         (out_status),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  task automatic expect_result(logic [VALUE_W-1:0] value, logic [PRIO_W-1:0] prio,
                               logic [STATUS_W-1:0] status, logic last);
    queue_result_t r;
    r.value  = value;
    r.prio   = prio;
    r.status = status;
    r.last   = last;
    expected_results.push_back(r);
  endtask

  // Applies one accepted command to the model and records the results it causes.
  task automatic predict_queue_results(logic [FUNC_W-1:0] func,
                                       logic signed [VALUE_W-1:0] value,
                                       logic signed [PRIO_W-1:0] prio);
    int pos;
    int n;
    n = model_prios.size();
    case (func)
      FUNC_INSERT: begin
        if (n >= SPQ_CAPACITY) begin
          expect_result('0, '0, ST_FULL, 1'b1);
        end else begin
          // Equal priorities stay first in, first out.
          pos = 0;
          while (pos < n && model_prios[pos] <= prio) pos++;
          model_values.insert(pos, value);
          model_prios.insert(pos, prio);
          expect_result('0, '0, ST_INSERTED, 1'b1);
        end
      end
      FUNC_POP: begin
        if (n == 0) begin
          expect_result('0, '0, ST_UNDERFLOW, 1'b1);
        end else begin
          expect_result(model_values.pop_front(), model_prios.pop_front(), ST_POPPED, 1'b1);
        end
      end
      FUNC_LIST: begin
        if (n == 0) begin
          expect_result('0, '0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) begin
            expect_result(model_values[i], model_prios[i], ST_LISTED, i == n - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Sends one command after a random idle gap and waits for its transfer.
  task automatic issue_command(logic [FUNC_W-1:0] func, logic signed [VALUE_W-1:0] value,
                               logic signed [PRIO_W-1:0] prio);
    int gap;
    gap = $urandom_range(0, idle_max);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_func         <= func;
    in_item_value   <= value;
    in_priority_req <= prio;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_queue_results(func, value, prio);
  endtask

  always @(posedge clk) begin : result_checker
    queue_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0,
                        64'({out_item_value_res, out_priority_res, out_status, out_last}));
      end else begin
        want = expected_results.pop_front();
        if (out_item_value_res !== want.value)
          report_mismatch("item value", 64'(want.value), 64'(out_item_value_res));
        if (out_priority_res !== want.prio)
          report_mismatch("priority", 64'(want.prio), 64'(out_priority_res));
        if (out_status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(out_status));
        if (out_last !== want.last)
          report_mismatch("last flag", 64'(want.last), 64'(out_last));
      end
    end
  end

  function automatic logic [PRIO_W-1:0] draw_prio();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 3))
      0: return PRIO_W'($urandom_range(0, 6)) - PRIO_W'(3);
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return r[PRIO_W-1:0];
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] draw_func(int insert_pct, int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return FUNC_INSERT;
    if (r < insert_pct + pop_pct) return FUNC_POP;
    if (r < 97) return FUNC_LIST;
    return FUNC_UNUSED;
  endfunction

  task automatic test_empty_queue();
    idle_max = 19;
    issue_command(FUNC_POP, 32'sd5, 16'sd5);
    issue_command(FUNC_LIST, -32'sd1, -16'sd1);
    issue_command(FUNC_UNUSED, 32'sd0, 16'sd0);
  endtask

  // Fills the queue back to back with extreme and tied priorities, overflows, lists, pops.
  task automatic test_fill_to_capacity();
    logic signed [PRIO_W-1:0] fill_prios [16] = '{
      16'sd0, -16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd0, 16'sd32767,
      -16'sd32768, 16'sd5, 16'sd5, -16'sd1, 16'sd100, -16'sd100, 16'sd0, 16'sd1};
    logic signed [VALUE_W-1:0] v;
    idle_max = 0;
    for (int i = 0; i < SPQ_CAPACITY; i++) begin
      case (i)
        0: v = 32'h7fffffff;
        1: v = 32'h80000000;
        2: v = 32'hffffffff;
        3: v = 32'h00000000;
        default: v = $urandom();
      endcase
      issue_command(FUNC_INSERT, v, fill_prios[i]);
    end
    issue_command(FUNC_INSERT, 32'h12345678, -16'sd32768);
    issue_command(FUNC_LIST, 32'sd0, 16'sd0);
    issue_command(FUNC_UNUSED, -32'sd1, -16'sd1);
    issue_command(FUNC_POP, 32'sd0, 16'sd0);
    issue_command(FUNC_POP, 32'sd0, 16'sd0);
  endtask

  // Alternates fill-biased and drain-biased phases so the queue swings between empty and full.
  task automatic test_random_traffic();
    int sent;
    logic [FUNC_W-1:0] func;
    for (int phase = 0; phase < 6; phase++) begin
      idle_max = (phase % 3 == 1) ? 0 : 19;
      sent = 0;
      while (sent < 56) begin
        func = (phase % 2 == 0) ? draw_func(65, 22) : draw_func(30, 57);
        issue_command(func, $urandom(), draw_prio());
        if (func != FUNC_UNUSED) sent++;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_func         = FUNC_INSERT;
    in_item_value   = '0;
    in_priority_req = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_fill_to_capacity();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
